// ===== rtl/command_line_tokenizer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Command line tokenizer assertion macros
// Shared concurrent assertion forms for the tokenizer core.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLTOK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, disabled during reset.
`define CLTOK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

// ===== rtl/cltok_pkg.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Token kinds, token and queue entry types, character codes and sizes.
// ----------------------------------------------------------------------------
package cltok_pkg;

  localparam int unsigned LINE_LENGTH = 256;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    KIND_NAME     = 4'd0,
    KIND_NUMBER   = 4'd1,
    KIND_STRING   = 4'd2,
    KIND_OPERATOR = 4'd3,
    KIND_COMMA    = 4'd4,
    KIND_LINE_END = 4'd5,
    KIND_ERROR    = 4'd6,
    KIND_OPEN     = 4'd7,
    KIND_CLOSE    = 4'd8
  } tok_kind_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Z     = 8'h7a;

  typedef struct packed {
    tok_kind_e   kind;
    logic [31:0] value;
    logic [7:0]  start_pos;
    logic [7:0]  end_pos;
  } tok_t;

  typedef struct packed {
    tok_t first;
    tok_t second;
    logic two;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic tok_t mk_tok(tok_kind_e kind, logic [31:0] value,
                                  logic [7:0] first_pos, logic [7:0] last_pos);
    tok_t t;
    t.kind      = kind;
    t.value     = value;
    t.start_pos = first_pos;
    t.end_pos   = last_pos;
    return t;
  endfunction

endpackage

// ===== rtl/cltok_front.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer front end
// Accepts one character per beat, tracks the scan mode and emits the tokens
// that the character completes as one queue entry.
// ----------------------------------------------------------------------------
module cltok_front #(
  parameter int unsigned LINE_LENGTH = cltok_pkg::LINE_LENGTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          char_byte_i,
  output logic                in_stall_o,
  input  cltok_pkg::q_status_t q_status_i,
  output logic                push_o,
  output cltok_pkg::q_entry_t entry_o
);

  localparam int unsigned PosW = $clog2(LINE_LENGTH);
  localparam logic [PosW-1:0] PosMax = PosW'(LINE_LENGTH - 1);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ZERO,
    MODE_DEC,
    MODE_HEX,
    MODE_NAME,
    MODE_STRING
  } mode_e;

  mode_e           mode_q, mode_d;
  logic [31:0]     acc_q, acc_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      begin_q, begin_d;

  logic [PosW+7:0] pos_ext;
  logic [7:0]      pos8;
  logic [7:0]      c;
  logic            accept;
  logic            is_digit, is_lower, is_hexl, is_op;
  logic [31:0]     acc_x10, acc_x16;
  logic [3:0]      hex_dig;
  cltok_pkg::tok_t scan_tok, fresh_tok;
  logic            scan_v, fresh_v, str_err, fresh;

  assign c        = char_byte_i;
  assign accept   = in_valid_i && !q_status_i.full;
  assign in_stall_o = q_status_i.full;
  assign pos_ext  = {8'd0, pos_q};
  assign pos8     = pos_ext[7:0];

  assign is_digit = (c >= cltok_pkg::CH_0) && (c <= cltok_pkg::CH_9);
  assign is_lower = (c >= cltok_pkg::CH_A) && (c <= cltok_pkg::CH_Z);
  assign is_hexl  = (c >= cltok_pkg::CH_A) && (c <= cltok_pkg::CH_F);
  assign is_op    = (c == cltok_pkg::CH_PLUS) || (c == cltok_pkg::CH_MINUS) ||
                    (c == cltok_pkg::CH_STAR) || (c == cltok_pkg::CH_SLASH);
  assign hex_dig  = is_digit ? c[3:0] : c[3:0] + 4'd9;
  assign acc_x10  = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, c[3:0]};
  assign acc_x16  = {acc_q[27:0], hex_dig};

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    begin_d  = begin_q;
    scan_tok = cltok_pkg::mk_tok(cltok_pkg::KIND_NUMBER, acc_q, begin_q, pos8);
    scan_v   = 1'b0;
    str_err  = 1'b0;
    fresh    = 1'b0;
    unique case (mode_q)
      MODE_STRING: begin
        if (c == cltok_pkg::CH_QUOTE) begin
          scan_tok = cltok_pkg::mk_tok(cltok_pkg::KIND_STRING, 32'd0, begin_q, pos8);
          scan_v   = 1'b1;
          mode_d   = MODE_IDLE;
        end else if (c == cltok_pkg::CH_NUL) begin
          scan_tok = cltok_pkg::mk_tok(cltok_pkg::KIND_ERROR, 32'd0, begin_q, pos8);
          scan_v   = 1'b1;
          str_err  = 1'b1;
          mode_d   = MODE_IDLE;
        end
      end
      MODE_ZERO, MODE_DEC: begin
        if (mode_q == MODE_ZERO && c == cltok_pkg::CH_X) begin
          mode_d = MODE_HEX;
        end else if (is_digit) begin
          acc_d  = acc_x10;
          mode_d = MODE_DEC;
        end else begin
          scan_v = 1'b1;
          fresh  = 1'b1;
        end
      end
      MODE_HEX: begin
        if (is_digit || is_hexl) begin
          acc_d = acc_x16;
        end else begin
          scan_v = 1'b1;
          fresh  = 1'b1;
        end
      end
      MODE_NAME: begin
        if (!(is_lower || c == cltok_pkg::CH_COLON)) begin
          scan_tok = cltok_pkg::mk_tok(cltok_pkg::KIND_NAME, 32'd0, begin_q, pos8);
          scan_v   = 1'b1;
          fresh    = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    fresh_tok = cltok_pkg::mk_tok(cltok_pkg::KIND_LINE_END, 32'd0, pos8, pos8);
    fresh_v   = str_err;
    if (fresh) begin
      mode_d = MODE_IDLE;
      if (is_digit) begin
        begin_d = pos8;
        acc_d   = {28'd0, c[3:0]};
        mode_d  = (c == cltok_pkg::CH_0) ? MODE_ZERO : MODE_DEC;
      end else if (is_lower) begin
        begin_d = pos8;
        mode_d  = MODE_NAME;
      end else if (c == cltok_pkg::CH_QUOTE) begin
        begin_d = pos8;
        mode_d  = MODE_STRING;
      end else if (is_op) begin
        fresh_tok = cltok_pkg::mk_tok(cltok_pkg::KIND_OPERATOR, {24'd0, c}, pos8, pos8);
        fresh_v   = 1'b1;
      end else if (c == cltok_pkg::CH_NUL) begin
        fresh_v = 1'b1;
      end else if (c == cltok_pkg::CH_LBRK) begin
        fresh_tok = cltok_pkg::mk_tok(cltok_pkg::KIND_OPEN, 32'd0, pos8, pos8);
        fresh_v   = 1'b1;
      end else if (c == cltok_pkg::CH_RBRK) begin
        fresh_tok = cltok_pkg::mk_tok(cltok_pkg::KIND_CLOSE, 32'd0, pos8, pos8);
        fresh_v   = 1'b1;
      end else if (c == cltok_pkg::CH_COMMA) begin
        fresh_tok = cltok_pkg::mk_tok(cltok_pkg::KIND_COMMA, 32'd0, pos8, pos8);
        fresh_v   = 1'b1;
      end else if (c != cltok_pkg::CH_SPACE) begin
        fresh_tok = cltok_pkg::mk_tok(cltok_pkg::KIND_ERROR, 32'd0, pos8, pos8);
        fresh_v   = 1'b1;
      end
    end

    if (c == cltok_pkg::CH_NUL) begin
      pos_d  = '0;
      mode_d = MODE_IDLE;
    end else begin
      pos_d = (pos_q == PosMax) ? '0 : pos_q + 1'b1;
    end
  end

  always_comb begin
    if (scan_v) begin
      entry_o.first  = scan_tok;
      entry_o.second = fresh_tok;
      entry_o.two    = fresh_v;
    end else begin
      entry_o.first  = fresh_tok;
      entry_o.second = fresh_tok;
      entry_o.two    = 1'b0;
    end
  end

  assign push_o = accept && (scan_v || fresh_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      acc_q   <= '0;
      pos_q   <= '0;
      begin_q <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
    end
  end

endmodule

// ===== rtl/cltok_fifo.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer token queue
// Short queue of token entries between the front end and the back end.
// ----------------------------------------------------------------------------
module cltok_fifo #(
  parameter int unsigned Depth = cltok_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cltok_pkg::q_entry_t  entry_i,
  input  logic                 pop_i,
  output cltok_pkg::q_entry_t  entry_o,
  output cltok_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [PtrW:0]   CntMax = (PtrW + 1)'(Depth);

  cltok_pkg::q_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == CntMax);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrMax) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrMax) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cltok_back.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer back end
// Splits each queue entry into single token beats behind an output register.
// ----------------------------------------------------------------------------
module cltok_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cltok_pkg::q_entry_t  entry_i,
  input  cltok_pkg::q_status_t q_status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cltok_pkg::tok_t      tok_o,
  output logic                 last_o
);

  logic            valid_q;
  logic            phase_q;
  cltok_pkg::tok_t tok_q;
  logic            last_q;
  logic            load, is_last;

  assign load    = !q_status_i.empty && (!valid_q || !out_stall_i);
  assign is_last = phase_q || !entry_i.two;
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= phase_q ? entry_i.second : entry_i.first;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        phase_q <= !is_last;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign tok_o       = tok_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/command_line_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// Command line tokenizer core
// Splits a character stream into name, number, string and punctuation tokens.
// ----------------------------------------------------------------------------
// One character is taken per clock while the four-entry token queue has room;
// a character yields zero, one or two tokens, and tokens leave one per clock
// while the output is not stalled, so the queue absorbs the difference when
// a character yields two tokens. A token reaches the output through the
// queue write on the accepting edge and then the output register. Positions
// count modulo LINE_LENGTH; the position fields carry their low eight bits.
`include "command_line_tokenizer_core_defines.svh"

module command_line_tokenizer_core #(
  parameter int unsigned LINE_LENGTH = cltok_pkg::LINE_LENGTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  char_byte_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [31:0] token_value_o,
  output logic [7:0]  start_pos_o,
  output logic [7:0]  end_pos_o,
  output logic        last_of_run_o
);

  cltok_pkg::q_status_t q_status;
  cltok_pkg::q_entry_t  push_entry, head_entry;
  cltok_pkg::tok_t      tok;
  logic                 push, pop;

  cltok_front #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .char_byte_i(char_byte_i),
    .in_stall_o (in_stall_o),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  cltok_fifo #(
    .Depth(cltok_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .status_o(q_status)
  );

  cltok_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (head_entry),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .tok_o      (tok),
    .last_o     (last_of_run_o)
  );

  assign token_kind_o  = tok.kind;
  assign token_value_o = tok.value;
  assign start_pos_o   = tok.start_pos;
  assign end_pos_o     = tok.end_pos;

  `CLTOK_ASSERT_IMP(a_value_zero, clk_i, rst_ni, out_valid_o && token_kind_o != cltok_pkg::KIND_NUMBER && token_kind_o != cltok_pkg::KIND_OPERATOR, token_value_o == 32'd0)
  `CLTOK_ASSERT_IMP(a_single_char, clk_i, rst_ni, out_valid_o && (token_kind_o == cltok_pkg::KIND_OPERATOR || token_kind_o == cltok_pkg::KIND_COMMA || token_kind_o == cltok_pkg::KIND_LINE_END || token_kind_o == cltok_pkg::KIND_OPEN || token_kind_o == cltok_pkg::KIND_CLOSE), start_pos_o == end_pos_o)
  `CLTOK_ASSERT_NXT(a_line_end_last, clk_i, rst_ni, in_valid_i && !in_stall_o && char_byte_i == cltok_pkg::CH_NUL && !out_valid_o && q_status.empty, !q_status.empty)
  `CLTOK_ASSERT_IMP(a_push_room, clk_i, rst_ni, push, !q_status.full)

endmodule

// ===== tb/command_line_tokenizer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command line tokenizer core testbench
// Feeds character beats (short directed lines, then random well-formed
// lines laced with noise, broken strings and long lines) under random idling
// on both sides. A scoreboard predicts the token beats of every accepted
// character and checks the output beats in order, field by field.
// ----------------------------------------------------------------------------
module command_line_tokenizer_core_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ZERO,
    MODE_DEC,
    MODE_HEX,
    MODE_NAME,
    MODE_STRING
  } scan_mode_e;

  typedef struct packed {
    cltok_pkg::tok_kind_e kind;
    logic [31:0]          value;
    logic [7:0]           start_pos;
    logic [7:0]           end_pos;
    logic                 last;
  } token_beat_t;

  class token_scoreboard;
    scan_mode_e  mode = MODE_IDLE;
    logic [31:0] accum = '0;
    int unsigned line_pos = 0;
    logic [7:0]  tok_begin = '0;
    token_beat_t batch[$];
    token_beat_t expected_tokens[$];
    int          errors = 0;

    function void add_token(cltok_pkg::tok_kind_e kind, logic [31:0] value,
                            logic [7:0] first, logic [7:0] last_pos);
      token_beat_t t;
      t.kind      = kind;
      t.value     = value;
      t.start_pos = first;
      t.end_pos   = last_pos;
      t.last      = 1'b0;
      batch.push_back(t);
    endfunction

    function void note_char(logic [7:0] c);
      logic [7:0] p;
      bit         fresh;
      bit         digit;
      bit         lower;
      p     = line_pos[7:0];
      fresh = 1'b0;
      digit = (c >= cltok_pkg::CH_0) && (c <= cltok_pkg::CH_9);
      lower = (c >= cltok_pkg::CH_A) && (c <= cltok_pkg::CH_Z);
      batch.delete();
      case (mode)
        MODE_STRING: begin
          if (c == cltok_pkg::CH_QUOTE) begin
            add_token(cltok_pkg::KIND_STRING, '0, tok_begin, p);
            mode = MODE_IDLE;
          end else if (c == cltok_pkg::CH_NUL) begin
            add_token(cltok_pkg::KIND_ERROR, '0, tok_begin, p);
            add_token(cltok_pkg::KIND_LINE_END, '0, p, p);
            mode = MODE_IDLE;
          end
        end
        MODE_ZERO, MODE_DEC: begin
          if (mode == MODE_ZERO && c == cltok_pkg::CH_X) begin
            mode = MODE_HEX;
          end else if (digit) begin
            accum = accum * 32'd10 + 32'(c - cltok_pkg::CH_0);
            mode  = MODE_DEC;
          end else begin
            add_token(cltok_pkg::KIND_NUMBER, accum, tok_begin, p);
            fresh = 1'b1;
          end
        end
        MODE_HEX: begin
          if (digit) begin
            accum = accum * 32'd16 + 32'(c - cltok_pkg::CH_0);
          end else if (c >= cltok_pkg::CH_A && c <= cltok_pkg::CH_F) begin
            accum = accum * 32'd16 + 32'(c - cltok_pkg::CH_A) + 32'd10;
          end else begin
            add_token(cltok_pkg::KIND_NUMBER, accum, tok_begin, p);
            fresh = 1'b1;
          end
        end
        MODE_NAME: begin
          if (!(lower || c == cltok_pkg::CH_COLON)) begin
            add_token(cltok_pkg::KIND_NAME, '0, tok_begin, p);
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase

      if (fresh) begin
        mode = MODE_IDLE;
        if (digit) begin
          tok_begin = p;
          accum     = 32'(c - cltok_pkg::CH_0);
          mode      = (c == cltok_pkg::CH_0) ? MODE_ZERO : MODE_DEC;
        end else if (lower) begin
          tok_begin = p;
          mode      = MODE_NAME;
        end else if (c == cltok_pkg::CH_QUOTE) begin
          tok_begin = p;
          mode      = MODE_STRING;
        end else if (c == cltok_pkg::CH_PLUS || c == cltok_pkg::CH_MINUS ||
                     c == cltok_pkg::CH_STAR || c == cltok_pkg::CH_SLASH) begin
          add_token(cltok_pkg::KIND_OPERATOR, 32'(c), p, p);
        end else if (c == cltok_pkg::CH_NUL) begin
          add_token(cltok_pkg::KIND_LINE_END, '0, p, p);
        end else if (c == cltok_pkg::CH_LBRK) begin
          add_token(cltok_pkg::KIND_OPEN, '0, p, p);
        end else if (c == cltok_pkg::CH_RBRK) begin
          add_token(cltok_pkg::KIND_CLOSE, '0, p, p);
        end else if (c == cltok_pkg::CH_COMMA) begin
          add_token(cltok_pkg::KIND_COMMA, '0, p, p);
        end else if (c != cltok_pkg::CH_SPACE) begin
          add_token(cltok_pkg::KIND_ERROR, '0, p, p);
        end
      end

      if (c == cltok_pkg::CH_NUL) begin
        line_pos = 0;
        mode     = MODE_IDLE;
      end else begin
        line_pos = (line_pos + 1) % cltok_pkg::LINE_LENGTH;
      end

      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_tokens.push_back(batch[i]);
    endfunction

    function void check_token(token_beat_t got);
      token_beat_t exp_tok;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token beat kind %0d value %0h", $time, got.kind,
                 got.value);
        errors++;
        return;
      end
      exp_tok = expected_tokens.pop_front();
      if (got.kind !== exp_tok.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, exp_tok.kind, got.kind);
        errors++;
      end
      if (got.value !== exp_tok.value) begin
        $display("%0t: value expected %0h actual %0h", $time, exp_tok.value, got.value);
        errors++;
      end
      if (got.start_pos !== exp_tok.start_pos) begin
        $display("%0t: start_pos expected %0d actual %0d", $time, exp_tok.start_pos,
                 got.start_pos);
        errors++;
      end
      if (got.end_pos !== exp_tok.end_pos) begin
        $display("%0t: end_pos expected %0d actual %0d", $time, exp_tok.end_pos,
                 got.end_pos);
        errors++;
      end
      if (got.last !== exp_tok.last) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time, exp_tok.last,
                 got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic [7:0]  char_byte_i;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  token_kind_o;
  logic [31:0] token_value_o;
  logic [7:0]  start_pos_o;
  logic [7:0]  end_pos_o;
  logic        last_of_run_o;

  token_scoreboard sb = new();
  logic [7:0]      char_stream[$];
  bit              no_gaps = 1'b0;
  bit              hold_off_req = 1'b0;
  int              hold_left = 0;
  int              cycle_count = 0;

  command_line_tokenizer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .char_byte_i   (char_byte_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .token_value_o (token_value_o),
    .start_pos_o   (start_pos_o),
    .end_pos_o     (end_pos_o),
    .last_of_run_o (last_of_run_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: check accepted beats, then choose next stall
  initial begin
    token_beat_t seen;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        seen.kind      = cltok_pkg::tok_kind_e'(token_kind_o);
        seen.value     = token_value_o;
        seen.start_pos = start_pos_o;
        seen.end_pos   = end_pos_o;
        seen.last      = last_of_run_o;
        sb.check_token(seen);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_gaps && ($urandom_range(0, 99) < 8);
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    while (!no_gaps && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_char(c);
  endtask

  function automatic void append_token();
    int         len;
    int         sel;
    logic [7:0] b;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        char_stream.push_back(cltok_pkg::CH_A + 8'($urandom_range(0, 25)));
        len = $urandom_range(0, 7);
        repeat (len) begin
          if ($urandom_range(0, 5) == 0) char_stream.push_back(cltok_pkg::CH_COLON);
          else char_stream.push_back(cltok_pkg::CH_A + 8'($urandom_range(0, 25)));
        end
      end
      3, 4, 5: begin
        len = $urandom_range(1, 12);
        repeat (len) char_stream.push_back(cltok_pkg::CH_0 + 8'($urandom_range(0, 9)));
      end
      6, 7: begin
        char_stream.push_back(cltok_pkg::CH_0);
        char_stream.push_back(cltok_pkg::CH_X);
        len = $urandom_range(0, 10);
        repeat (len) begin
          sel = $urandom_range(0, 15);
          char_stream.push_back(sel < 10 ? cltok_pkg::CH_0 + 8'(sel)
                                         : cltok_pkg::CH_A + 8'(sel - 10));
        end
      end
      8, 9: begin
        char_stream.push_back(cltok_pkg::CH_QUOTE);
        len = $urandom_range(0, 6);
        repeat (len) begin
          b = 8'($urandom_range(1, 255));
          char_stream.push_back(b == cltok_pkg::CH_QUOTE ? cltok_pkg::CH_SPACE : b);
        end
        if ($urandom_range(0, 7) != 0) char_stream.push_back(cltok_pkg::CH_QUOTE);
      end
      10, 11: begin
        case ($urandom_range(0, 3))
          0: char_stream.push_back(cltok_pkg::CH_PLUS);
          1: char_stream.push_back(cltok_pkg::CH_MINUS);
          2: char_stream.push_back(cltok_pkg::CH_STAR);
          default: char_stream.push_back(cltok_pkg::CH_SLASH);
        endcase
      end
      12: char_stream.push_back(cltok_pkg::CH_COMMA);
      13: char_stream.push_back(cltok_pkg::CH_LBRK);
      14: char_stream.push_back(cltok_pkg::CH_RBRK);
      15, 16: char_stream.push_back(8'($urandom_range(1, 255)));
      default: ;
    endcase
    if ($urandom_range(0, 2) != 0) begin
      len = $urandom_range(1, 3);
      repeat (len) char_stream.push_back(cltok_pkg::CH_SPACE);
    end
  endfunction

  initial begin
    string opening;
    int    tokens;
    bit    long_done;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_byte_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    opening = "a:b19x+0xf,[]\"z\":0 *-/";
    for (int i = 0; i < opening.len(); i++) char_stream.push_back(opening[i]);
    char_stream.push_back(8'hff);
    char_stream.push_back(cltok_pkg::CH_QUOTE);
    char_stream.push_back(cltok_pkg::CH_NUL);
    char_stream.push_back(cltok_pkg::CH_0);
    char_stream.push_back(cltok_pkg::CH_X);
    char_stream.push_back(cltok_pkg::CH_NUL);
    foreach (char_stream[i]) send_char(char_stream[i]);
    char_stream.delete();

    long_done = 1'b0;
    while (char_stream.size() < 400) begin
      if (!long_done) tokens = 70;
      else tokens = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 10);
      long_done = 1'b1;
      repeat (tokens) append_token();
      char_stream.push_back(cltok_pkg::CH_NUL);
    end

    foreach (char_stream[i]) begin
      no_gaps = (i >= 200 && i < 300);
      if (i == 120) hold_off_req = 1'b1;
      if (i == 320) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.expected_tokens.size() != 0) @(posedge clk_i);
      end
      send_char(char_stream[i]);
    end
    no_gaps = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cltok_pkg.sv
rtl/cltok_front.sv
rtl/cltok_fifo.sv
rtl/cltok_back.sv
rtl/command_line_tokenizer_core.sv
tb/command_line_tokenizer_core_tb.sv
